// ----- src/quadratic_root_solver_top_macros.svh -----
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m");
`define QRS_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m");
`else
`define QRS_ASSERT(label, clk, rst_n, prop)
`define QRS_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- src/qrs_pkg.sv -----
// Package with shared constants for the quadratic root solver.
`default_nettype none
package qrs_pkg;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int ROOT_W         = 32;
    localparam logic [1:0] ST_A_ZERO  = 2'd0;
    localparam logic [1:0] ST_NO_REAL = 2'd1;
    localparam logic [1:0] ST_ONE     = 2'd2;
    localparam logic [1:0] ST_TWO     = 2'd3;
endpackage
`default_nettype wire

// ----- src/qrs_sqrt_cell.sv -----
// One restoring square root step: consumes two radicand bits, yields one root bit.
`default_nettype none
module qrs_sqrt_cell #(
    parameter int RW = 34,
    parameter int SW = 34
) (
    input  wire  logic          i_clk,
    input  wire  logic          i_en,
    input  wire  logic [RW-1:0] i_rad,
    input  wire  logic [SW-1:0] i_root,
    input  wire  logic [SW+1:0] i_rem,
    output logic [RW-1:0] o_rad,
    output logic [SW-1:0] o_root,
    output logic [SW+1:0] o_rem
);
    logic [SW+1:0] n_rem;
    logic [SW+1:0] n_trial;
    logic [SW-1:0] n_root;
    always_comb begin
        n_rem   = {i_rem[SW-1:0], i_rad[RW-1 -: 2]};
        n_trial = {i_root, 2'b01};
        if (n_rem >= n_trial) begin
            n_rem  = n_rem - n_trial;
            n_root = {i_root[SW-2:0], 1'b1};
        end else begin
            n_root = {i_root[SW-2:0], 1'b0};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[RW-3:0], 2'b00};
            o_root <= n_root;
            o_rem  <= n_rem;
        end
    end
endmodule
`default_nettype wire

// ----- src/qrs_div_cell.sv -----
// One restoring division step for two quotients sharing one divisor.
`default_nettype none
module qrs_div_cell #(
    parameter int NW = 64,
    parameter int DW = 34
) (
    input  wire  logic          i_clk,
    input  wire  logic          i_en,
    input  wire  logic [DW-1:0] i_den,
    input  wire  logic [NW-1:0] i_num_p,
    input  wire  logic [DW:0]   i_rem_p,
    input  wire  logic [NW-1:0] i_num_m,
    input  wire  logic [DW:0]   i_rem_m,
    output logic [DW-1:0] o_den,
    output logic [NW-1:0] o_num_p,
    output logic [DW:0]   o_rem_p,
    output logic [NW-1:0] o_num_m,
    output logic [DW:0]   o_rem_m
);
    logic [DW:0] n_tp, n_tm;
    always_comb begin
        n_tp = {i_rem_p[DW-1:0], i_num_p[NW-1]};
        n_tm = {i_rem_m[DW-1:0], i_num_m[NW-1]};
    end
    // Quotient bits shift into the low end of the numerator word.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den <= i_den;
            if (n_tp >= {1'b0, i_den}) begin
                o_rem_p <= n_tp - {1'b0, i_den};
                o_num_p <= {i_num_p[NW-2:0], 1'b1};
            end else begin
                o_rem_p <= n_tp;
                o_num_p <= {i_num_p[NW-2:0], 1'b0};
            end
            if (n_tm >= {1'b0, i_den}) begin
                o_rem_m <= n_tm - {1'b0, i_den};
                o_num_m <= {i_num_m[NW-2:0], 1'b1};
            end else begin
                o_rem_m <= n_tm;
                o_num_m <= {i_num_m[NW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/quadratic_root_solver_top.sv -----
// Top level of the pipelined quadratic root solver.
`default_nettype none
`include "quadratic_root_solver_top_macros.svh"
// Pipelined real-root solver for a*x^2+b*x+c with signed fixed-point coefficients and
// signed Q16.16 roots. A request is taken every cycle while the output side keeps up;
// the pipe holds three front stages, the chain of square root cells, the chain of
// shared-divisor division cells and the output register. The number of fraction bits
// cancels in the quotient, so it does not change the arithmetic. The whole pipe stalls
// as one when a finished result is not taken.
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  wire  logic                         i_clk,
    input  wire  logic                         i_rst_n,
    input  wire  logic                         i_valid,
    output logic                               o_ready,
    input  wire  logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  wire  logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  wire  logic signed [COEF_WIDTH-1:0] i_coef_c,
    output logic                               o_valid,
    input  wire  logic                         i_ready,
    output logic [1:0]                         o_root_status,
    output logic signed [qrs_pkg::ROOT_W-1:0]  o_root_plus,
    output logic signed [qrs_pkg::ROOT_W-1:0]  o_root_minus,
    output logic                               o_overflow_flag
);
    import qrs_pkg::*;
    localparam int CW  = COEF_WIDTH;
    localparam int DSW = 2*CW + 2;            // discriminant width (even)
    localparam int SQW = DSW/2;               // sqrt width
    localparam int NSQ = SQW;                 // sqrt cells
    localparam int MW  = SQW + 1;             // numerator magnitude width
    localparam int NW  = MW + 16;             // shifted numerator width
    localparam int DW  = CW + 2;              // |2a| width
    localparam int LAT = 4 + NSQ + NW;
    localparam int QW  = (NW > ROOT_W) ? NW : ROOT_W + 1;

    logic adv;
    logic [LAT-1:0] r_vld;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LAT-2:0], i_valid};
    end
    assign o_valid = r_vld[LAT-1];

    typedef struct packed {
        logic [1:0]    st;
        logic          bn;
        logic          an;
        logic [CW-1:0] bm;
        logic [DW-1:0] den;
    } t_side;

    // Stage 1: magnitudes.
    logic [CW-1:0] r_am, r_bm, r_cm;
    logic r_an, r_bn, r_cn;
    // Stage 2: products.
    logic [2*CW-1:0] r_bb, r_p;
    logic [CW-1:0] r2_am, r2_bm;
    logic r2_an, r2_bn, r2_cn;
    // Stage 3: discriminant and status.
    logic [DSW-1:0] r_disc;
    t_side r3_s;
    logic [DSW-1:0] n_disc;
    logic [1:0] n_st;
    always_comb begin
        logic [DSW-1:0] bbx, q4;
        bbx = {2'b00, r_bb};
        q4  = {r_p, 2'b00};
        n_disc = '0;
        if (r2_am == '0) n_st = ST_A_ZERO;
        else if (r_p == '0 || r2_an != r2_cn) begin
            n_disc = bbx + q4;
            n_st = (n_disc == '0) ? ST_ONE : ST_TWO;
        end else if (q4 > bbx) n_st = ST_NO_REAL;
        else begin
            n_disc = bbx - q4;
            n_st = (n_disc == '0) ? ST_ONE : ST_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_an <= i_coef_a[CW-1]; r_bn <= i_coef_b[CW-1]; r_cn <= i_coef_c[CW-1];
            r_am <= i_coef_a[CW-1] ? CW'(-i_coef_a) : CW'(i_coef_a);
            r_bm <= i_coef_b[CW-1] ? CW'(-i_coef_b) : CW'(i_coef_b);
            r_cm <= i_coef_c[CW-1] ? CW'(-i_coef_c) : CW'(i_coef_c);
            r_bb <= (2*CW)'(r_bm) * (2*CW)'(r_bm);
            r_p  <= (2*CW)'(r_am) * (2*CW)'(r_cm);
            r2_am <= r_am; r2_bm <= r_bm;
            r2_an <= r_an; r2_bn <= r_bn; r2_cn <= r_cn;
            r_disc <= n_disc;
            r3_s.st <= n_st; r3_s.bn <= r2_bn; r3_s.an <= r2_an; r3_s.bm <= r2_bm;
            r3_s.den <= {1'b0, r2_am, 1'b0};
        end
    end

    // Square root chain; side info follows in a matching shift line.
    logic [DSW-1:0]   sq_rad  [NSQ+1];
    logic [SQW-1:0]   sq_root [NSQ+1];
    logic [SQW+1:0]   sq_rem  [NSQ+1];
    t_side            sq_s    [NSQ+1];
    assign sq_rad[0]  = r_disc;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;
    assign sq_s[0]    = r3_s;
    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        logic [DSW-1:0] w_rad;
        logic [SQW-1:0] w_root;
        logic [SQW+1:0] w_rem;
        t_side r_s;
        qrs_sqrt_cell #(.RW(DSW), .SW(SQW)) u_cell (
            .i_clk(i_clk), .i_en(adv), .i_rad(sq_rad[k]),
            .i_root(sq_root[k]), .i_rem(sq_rem[k]),
            .o_rad(w_rad), .o_root(w_root), .o_rem(w_rem)
        );
        assign sq_rad[k+1]  = w_rad;
        assign sq_root[k+1] = w_root;
        assign sq_rem[k+1]  = w_rem;
        always_ff @(posedge i_clk) begin
            if (adv) r_s <= sq_s[k];
        end
        assign sq_s[k+1] = r_s;
    end

    // Numerator forming (combinational on the sqrt output, registered into div chain).
    logic [SQW-1:0] s;
    t_side ss;
    assign s  = sq_root[NSQ];
    assign ss = sq_s[NSQ];
    logic [MW-1:0] np_mag, nm_mag, bmx, sx;
    logic np_neg, nm_neg;
    always_comb begin
        bmx = MW'(ss.bm);
        sx  = MW'(s);
        if (ss.st == ST_ONE) begin
            np_neg = !ss.bn; np_mag = bmx; nm_neg = 1'b0; nm_mag = '0;
        end else begin
            if (ss.bn) begin np_neg = 1'b0; np_mag = bmx + sx; end
            else if (sx >= bmx) begin np_neg = 1'b0; np_mag = sx - bmx; end
            else begin np_neg = 1'b1; np_mag = bmx - sx; end
            if (!ss.bn) begin nm_neg = 1'b1; nm_mag = bmx + sx; end
            else if (bmx >= sx) begin nm_neg = 1'b0; nm_mag = bmx - sx; end
            else begin nm_neg = 1'b1; nm_mag = sx - bmx; end
        end
    end

    typedef struct packed {
        logic [1:0] st;
        logic       pn;
        logic       mn;
    } t_sign;

    logic [DW-1:0] dv_den  [NW+1];
    logic [NW-1:0] dv_np   [NW+1];
    logic [DW:0]   dv_rp   [NW+1];
    logic [NW-1:0] dv_nm   [NW+1];
    logic [DW:0]   dv_rm   [NW+1];
    t_sign         dv_s    [NW+1];
    assign dv_den[0] = ss.den;
    assign dv_np[0]  = {np_mag, 16'd0};
    assign dv_nm[0]  = {nm_mag, 16'd0};
    assign dv_rp[0]  = '0;
    assign dv_rm[0]  = '0;
    assign dv_s[0]   = '{st: ss.st, pn: np_neg != ss.an, mn: nm_neg != ss.an};
    for (genvar k = 0; k < NW; k++) begin : g_dv
        logic [DW-1:0] w_den;
        logic [NW-1:0] w_np, w_nm;
        logic [DW:0]   w_rp, w_rm;
        t_sign r_s;
        qrs_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .i_clk(i_clk), .i_en(adv), .i_den(dv_den[k]),
            .i_num_p(dv_np[k]), .i_rem_p(dv_rp[k]),
            .i_num_m(dv_nm[k]), .i_rem_m(dv_rm[k]),
            .o_den(w_den), .o_num_p(w_np), .o_rem_p(w_rp),
            .o_num_m(w_nm), .o_rem_m(w_rm)
        );
        assign dv_den[k+1] = w_den;
        assign dv_np[k+1]  = w_np;
        assign dv_nm[k+1]  = w_nm;
        assign dv_rp[k+1]  = w_rp;
        assign dv_rm[k+1]  = w_rm;
        always_ff @(posedge i_clk) begin
            if (adv) r_s <= dv_s[k];
        end
        assign dv_s[k+1] = r_s;
    end

    function automatic logic [ROOT_W:0] sat(input logic [NW-1:0] q, input logic neg);
        logic [ROOT_W:0] r;
        logic [QW-1:0] qx;
        logic ng;
        qx = QW'(q);
        ng = neg && (q != '0);
        if (!ng) begin
            if (qx > QW'(33'h0_7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
            else r = {1'b0, qx[ROOT_W-1:0]};
        end else begin
            if (qx > QW'(33'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
            else r = {1'b0, 32'(-qx[ROOT_W-1:0])};
        end
        return r;
    endfunction

    logic [ROOT_W:0] rp, rm;
    t_sign fs;
    assign fs = dv_s[NW];
    assign rp = sat(dv_np[NW], fs.pn);
    assign rm = sat(dv_nm[NW], fs.mn);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_root_status <= fs.st;
            if (fs.st == ST_ONE || fs.st == ST_TWO) begin
                o_root_plus <= rp[ROOT_W-1:0];
                o_root_minus <= (fs.st == ST_TWO) ? rm[ROOT_W-1:0] : '0;
                o_overflow_flag <= rp[ROOT_W] || ((fs.st == ST_TWO) && rm[ROOT_W]);
            end else begin
                o_root_plus <= '0; o_root_minus <= '0; o_overflow_flag <= 1'b0;
            end
        end
    end

    `QRS_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
    `QRS_ASSERT(a_ready, i_clk, i_rst_n, (!o_valid) |-> o_ready)
    `QRS_ASSERT(a_status, i_clk, i_rst_n, (o_valid && o_root_status == ST_A_ZERO) |-> (o_root_plus == '0 && !o_overflow_flag))
endmodule
`default_nettype wire
